### hw/rtl/dde_pkg.sv
`default_nettype none

package dde_pkg;

    // Table dimensions
    localparam int PROCS     = 8;
    localparam int RESOURCES = 4;

    // Field and store widths
    localparam int AMT_W     = 12;
    localparam int AVAIL_W   = 16;
    localparam int PROC_F_W  = 3;
    localparam int RES_F_W   = 2;
    localparam int TYPE_W    = 2;
    localparam int KIND_W    = 2;

    // Derived index and counter widths
    localparam int PW        = (PROCS > 1) ? $clog2(PROCS) : 1;
    localparam int RW        = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
    localparam int MAT_DEPTH = PROCS * RESOURCES;
    localparam int MAT_IDX_W = (MAT_DEPTH > 1) ? $clog2(MAT_DEPTH) : 1;
    localparam int CNT_W     = $clog2(PROCS + 1);

    // Input item codes
    typedef enum logic [TYPE_W-1:0] {
        REQ_LOAD_AVAIL = 2'd0,
        REQ_LOAD_ALLOC = 2'd1,
        REQ_LOAD_REQ   = 2'd2,
        REQ_RUN        = 2'd3
    } req_type_t;

    // Result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_SERVED  = 2'd0,
        KIND_DEAD    = 2'd1,
        KIND_VERDICT = 2'd2
    } kind_t;

    // Write and read control for the allocation/request tables
    typedef struct packed {
        logic                 wr_alloc;
        logic                 wr_req;
        logic [MAT_IDX_W-1:0] wr_idx;
        logic [AMT_W-1:0]     wr_data;
        logic [MAT_IDX_W-1:0] rd_idx;
    } mat_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/dde_matrix.sv
`default_nettype none

// Allocation and request tables, one write and one read address per cycle
module dde_matrix (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire dde_pkg::mat_ctl_t         ctl,
    output logic [dde_pkg::AMT_W-1:0]      alloc_rd,
    output logic [dde_pkg::AMT_W-1:0]      req_rd
);

    logic [dde_pkg::AMT_W-1:0] alloc_reg [dde_pkg::MAT_DEPTH];
    logic [dde_pkg::AMT_W-1:0] req_reg   [dde_pkg::MAT_DEPTH];

    // Write loads and serve clears
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < dde_pkg::MAT_DEPTH; i++)
            begin
                alloc_reg[i] <= '0;
                req_reg[i]   <= '0;
            end
        end
        else
        begin
            if (ctl.wr_alloc)
            begin
                alloc_reg[ctl.wr_idx] <= ctl.wr_data;
            end
            if (ctl.wr_req)
            begin
                req_reg[ctl.wr_idx] <= ctl.wr_data;
            end
        end
    end

    // Read the entry under the sequencer's cursor
    assign alloc_rd = alloc_reg[ctl.rd_idx];
    assign req_rd   = req_reg[ctl.rd_idx];

endmodule

`default_nettype wire

### hw/rtl/deadlock_detection_engine.sv
`default_nettype none

// Deadlock detection engine.
// Input stream (s_axis): tuser selects the item kind (load available, load
// allocation, load request, run). tdata carries proc, resource and amount.
// Loads write one table entry and give no result.
// A run clears the served flags and sweeps processes in index order with a
// single compare/add unit: it checks a process's requests against available
// one resource at a time, releases its allocation one resource at a time
// (saturating at 65535), then steps to the next process. Sweeps repeat until
// one serves nobody, and then the results are reported. tready is low for the
// whole run and while it reports.
// Output stream (m_axis): PROCS + 1 transfers per run: served processes in
// serving order, deadlocked processes in index order, then the verdict with
// tlast high. deadlock is set on every transfer of a deadlocked run.
// Results sit in one output register; when the receiver stalls the report
// waits, and a new item can be accepted while the verdict is still pending.
// Reset clears all tables and counters and empties the output register.
module deadlock_detection_engine (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // proc[2:0], resource[4:3], amount[16:5]
    input  wire logic [1:0]  s_axis_tuser,   // req_type[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // proc_res[2:0], deadlock[3]
    output logic [1:0]       m_axis_tuser,   // kind[1:0]
    output logic             m_axis_tlast
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SERVE,
        ST_STEP,
        ST_EMIT_SRV,
        ST_EMIT_DEAD,
        ST_EMIT_VERD
    } state_t;

    state_t                        state_reg, state_next;
    logic [dde_pkg::PW-1:0]        p_reg, p_next;
    logic [dde_pkg::RW-1:0]        r_reg, r_next;
    logic [dde_pkg::CNT_W-1:0]     e_reg, e_next;
    logic [dde_pkg::CNT_W-1:0]     count_reg, count_next;
    logic                          prog_reg, prog_next;
    logic [dde_pkg::PROCS-1:0]     flags_reg, flags_next;

    logic                          m_valid_reg, m_valid_next;
    dde_pkg::kind_t                m_kind_reg, m_kind_next;
    logic [dde_pkg::PROC_F_W-1:0]  m_proc_reg, m_proc_next;
    logic                          m_dl_reg, m_dl_next;
    logic                          m_last_reg, m_last_next;

    logic [dde_pkg::AVAIL_W-1:0]   avail_reg [dde_pkg::RESOURCES];
    logic [dde_pkg::PW-1:0]        order_reg [dde_pkg::PROCS];

    logic                          avail_we;
    logic [dde_pkg::RW-1:0]        avail_widx;
    logic [dde_pkg::AVAIL_W-1:0]   avail_wdata;
    logic                          order_we;

    dde_pkg::mat_ctl_t             mat_ctl;
    logic [dde_pkg::AMT_W-1:0]     alloc_rd;
    logic [dde_pkg::AMT_W-1:0]     req_rd;

    logic                          s_fire;
    logic                          out_free;
    logic                          dl;
    logic [dde_pkg::PROC_F_W-1:0]  in_proc;
    logic [dde_pkg::RES_F_W-1:0]   in_res;
    logic [dde_pkg::AMT_W-1:0]     in_amt;
    logic                          in_proc_ok;
    logic                          in_res_ok;
    logic [dde_pkg::AVAIL_W-1:0]   avail_cur;
    logic [dde_pkg::AVAIL_W:0]     avail_sum;
    logic                          p_last;
    logic                          r_last;

    // Unpack the input transfer
    assign in_proc    = s_axis_tdata[2:0];
    assign in_res     = s_axis_tdata[4:3];
    assign in_amt     = s_axis_tdata[16:5];
    assign in_proc_ok = 32'(in_proc) < dde_pkg::PROCS;
    assign in_res_ok  = 32'(in_res) < dde_pkg::RESOURCES;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    assign p_last    = (p_reg == dde_pkg::PW'(dde_pkg::PROCS - 1));
    assign r_last    = (r_reg == dde_pkg::RW'(dde_pkg::RESOURCES - 1));
    assign dl        = (count_reg != dde_pkg::CNT_W'(dde_pkg::PROCS));
    assign avail_cur = avail_reg[r_reg];
    assign avail_sum = {1'b0, avail_cur} + (dde_pkg::AVAIL_W + 1)'(alloc_rd);

    dde_matrix u_matrix (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (mat_ctl),
        .alloc_rd (alloc_rd),
        .req_rd   (req_rd)
    );

    // Sequencer next state
    always_comb
    begin
        state_next   = state_reg;
        p_next       = p_reg;
        r_next       = r_reg;
        e_next       = e_reg;
        count_next   = count_reg;
        prog_next    = prog_reg;
        flags_next   = flags_reg;
        m_valid_next = m_valid_reg;
        m_kind_next  = m_kind_reg;
        m_proc_next  = m_proc_reg;
        m_dl_next    = m_dl_reg;
        m_last_next  = m_last_reg;
        avail_we     = 1'b0;
        avail_widx   = r_reg;
        avail_wdata  = '0;
        order_we     = 1'b0;

        mat_ctl.wr_alloc = 1'b0;
        mat_ctl.wr_req   = 1'b0;
        mat_ctl.wr_idx   = dde_pkg::MAT_IDX_W'(32'(in_proc) * dde_pkg::RESOURCES
                                                + 32'(in_res));
        mat_ctl.wr_data  = in_amt;
        mat_ctl.rd_idx   = dde_pkg::MAT_IDX_W'(32'(p_reg) * dde_pkg::RESOURCES
                                                + 32'(r_reg));

        // Drop the output once it is taken
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    unique case (dde_pkg::req_type_t'(s_axis_tuser))
                        dde_pkg::REQ_LOAD_AVAIL:
                        begin
                            avail_we    = in_res_ok;
                            avail_widx  = dde_pkg::RW'(in_res);
                            avail_wdata = dde_pkg::AVAIL_W'(in_amt);
                        end
                        dde_pkg::REQ_LOAD_ALLOC:
                        begin
                            mat_ctl.wr_alloc = in_proc_ok && in_res_ok;
                        end
                        dde_pkg::REQ_LOAD_REQ:
                        begin
                            mat_ctl.wr_req = in_proc_ok && in_res_ok;
                        end
                        dde_pkg::REQ_RUN:
                        begin
                            flags_next = '0;
                            count_next = '0;
                            prog_next  = 1'b0;
                            p_next     = '0;
                            r_next     = '0;
                            state_next = ST_CHECK;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            // Compare one request against available per cycle
            ST_CHECK:
            begin
                if (flags_reg[p_reg] ||
                    (dde_pkg::AVAIL_W'(req_rd) > avail_cur))
                begin
                    r_next     = '0;
                    state_next = ST_STEP;
                end
                else if (r_last)
                begin
                    r_next     = '0;
                    state_next = ST_SERVE;
                end
                else
                begin
                    r_next = r_reg + 1'b1;
                end
            end

            // Release one allocation per cycle, saturating available
            ST_SERVE:
            begin
                avail_we         = 1'b1;
                avail_wdata      = avail_sum[dde_pkg::AVAIL_W] ? '1
                                   : avail_sum[dde_pkg::AVAIL_W-1:0];
                mat_ctl.wr_alloc = 1'b1;
                mat_ctl.wr_idx   = mat_ctl.rd_idx;
                mat_ctl.wr_data  = '0;
                if (r_last)
                begin
                    r_next            = '0;
                    flags_next[p_reg] = 1'b1;
                    order_we          = 1'b1;
                    count_next        = count_reg + 1'b1;
                    prog_next         = 1'b1;
                    state_next        = ST_STEP;
                end
                else
                begin
                    r_next = r_reg + 1'b1;
                end
            end

            // Advance to the next process; rescan while a sweep made progress
            ST_STEP:
            begin
                r_next = '0;
                if (p_last)
                begin
                    p_next = '0;
                    if (prog_reg)
                    begin
                        prog_next  = 1'b0;
                        state_next = ST_CHECK;
                    end
                    else
                    begin
                        e_next     = '0;
                        state_next = ST_EMIT_SRV;
                    end
                end
                else
                begin
                    p_next     = p_reg + 1'b1;
                    state_next = ST_CHECK;
                end
            end

            // Report served processes in serving order
            ST_EMIT_SRV:
            begin
                if (e_reg == count_reg)
                begin
                    p_next     = '0;
                    state_next = ST_EMIT_DEAD;
                end
                else if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_kind_next  = dde_pkg::KIND_SERVED;
                    m_proc_next  = dde_pkg::PROC_F_W'(order_reg[e_reg[dde_pkg::PW-1:0]]);
                    m_dl_next    = dl;
                    m_last_next  = 1'b0;
                    e_next       = e_reg + 1'b1;
                end
            end

            // Report unserved processes in index order
            ST_EMIT_DEAD:
            begin
                if (flags_reg[p_reg] || out_free)
                begin
                    if (!flags_reg[p_reg])
                    begin
                        m_valid_next = 1'b1;
                        m_kind_next  = dde_pkg::KIND_DEAD;
                        m_proc_next  = dde_pkg::PROC_F_W'(p_reg);
                        m_dl_next    = dl;
                        m_last_next  = 1'b0;
                    end
                    if (p_last)
                    begin
                        p_next     = '0;
                        state_next = ST_EMIT_VERD;
                    end
                    else
                    begin
                        p_next = p_reg + 1'b1;
                    end
                end
            end

            ST_EMIT_VERD:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_kind_next  = dde_pkg::KIND_VERDICT;
                    m_proc_next  = '0;
                    m_dl_next    = dl;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold sequencer state and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            p_reg       <= '0;
            r_reg       <= '0;
            e_reg       <= '0;
            count_reg   <= '0;
            prog_reg    <= 1'b0;
            flags_reg   <= '0;
            m_valid_reg <= 1'b0;
            m_kind_reg  <= dde_pkg::KIND_SERVED;
            m_proc_reg  <= '0;
            m_dl_reg    <= 1'b0;
            m_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            p_reg       <= p_next;
            r_reg       <= r_next;
            e_reg       <= e_next;
            count_reg   <= count_next;
            prog_reg    <= prog_next;
            flags_reg   <= flags_next;
            m_valid_reg <= m_valid_next;
            m_kind_reg  <= m_kind_next;
            m_proc_reg  <= m_proc_next;
            m_dl_reg    <= m_dl_next;
            m_last_reg  <= m_last_next;
        end
    end

    // Available vector and serving order
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < dde_pkg::RESOURCES; i++)
            begin
                avail_reg[i] <= '0;
            end
            for (int i = 0; i < dde_pkg::PROCS; i++)
            begin
                order_reg[i] <= '0;
            end
        end
        else
        begin
            if (avail_we)
            begin
                avail_reg[avail_widx] <= avail_wdata;
            end
            if (order_we)
            begin
                order_reg[count_reg[dde_pkg::PW-1:0]] <= p_reg;
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_kind_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tdata  = {4'b0000, m_dl_reg, m_proc_reg};

    // Served count never passes the process count
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= dde_pkg::PROCS)
        else $error("served count out of range");

    // tlast marks exactly the verdict
    a_last_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == dde_pkg::KIND_VERDICT)))
        else $error("tlast does not match verdict");

    // A deadlocked process only appears in a deadlocked run
    a_dead_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == dde_pkg::KIND_DEAD)) |-> m_axis_tdata[3])
        else $error("deadlocked process reported without verdict flag");

endmodule

`default_nettype wire
